// ----- src/tcp_passive_open_responder_macros.svh -----
// ----------------------------------------------------------------------------
// TCP passive-open responder assertion macros
// Shared assertion wrappers; defining ASSERT_OFF removes all of them.
// ----------------------------------------------------------------------------
`ifndef TCP_PASSIVE_OPEN_RESPONDER_MACROS_SVH
`define TCP_PASSIVE_OPEN_RESPONDER_MACROS_SVH

`ifndef ASSERT_OFF

`define TPOR_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`define TPOR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define TPOR_ASSERT_IMPL(label, clk, rst, cond, prop, msg)

`define TPOR_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

// ----- src/tpor_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP passive-open responder package
// Types, codes and reset values shared by the responder modules.
// ----------------------------------------------------------------------------
package tpor_pkg;

  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_SYNACK = 2'd1;
  localparam logic [1:0] ST_ESTAB  = 2'd2;

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SYNACK = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  localparam logic [2:0] EV_WRONG_PORT    = 3'd0;
  localparam logic [2:0] EV_SYN_ACCEPTED  = 3'd1;
  localparam logic [2:0] EV_SYN_IGNORED   = 3'd2;
  localparam logic [2:0] EV_ESTABLISHED   = 3'd3;
  localparam logic [2:0] EV_ACK_MISMATCH  = 3'd4;
  localparam logic [2:0] EV_NOT_CONNECTED = 3'd5;
  localparam logic [2:0] EV_DATA          = 3'd6;
  localparam logic [2:0] EV_OTHER         = 3'd7;

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_LOCAL_PORT       = 2'd0;
  localparam logic [1:0] REG_INITIAL_SEQUENCE = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd2;

  localparam logic [15:0] LOCAL_PORT_RESET       = 16'd15118;
  localparam logic [31:0] INITIAL_SEQUENCE_RESET = 32'h0102_0304;
  localparam logic [15:0] MAX_PAYLOAD_RESET      = 16'd1000;

  typedef struct packed {
    logic [15:0] local_port;
    logic [31:0] initial_sequence;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ip_payload_length;
    logic [3:0]  data_offset;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] remote_seq;
    logic [31:0] remote_ack;
    logic [7:0]  segment_flags;
  } seg_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [7:0]  reply_flags;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [15:0] reply_port;
    logic [15:0] delivered_length;
    logic [1:0]  connection_state;
    logic [2:0]  event_code;
  } reply_t;

endpackage

// ----- src/tpor_seg_if.sv -----
// ----------------------------------------------------------------------------
// TCP segment header channel
// Valid/ready channel carrying the parsed header fields of one segment.
// ----------------------------------------------------------------------------
interface tpor_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] ip_payload_length;
  logic [3:0]  data_offset;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] remote_seq;
  logic [31:0] remote_ack;
  logic [7:0]  segment_flags;

  modport source (
    output valid, ip_payload_length, data_offset, source_port, dest_port,
           remote_seq, remote_ack, segment_flags,
    input  ready
  );

  modport sink (
    input  valid, ip_payload_length, data_offset, source_port, dest_port,
           remote_seq, remote_ack, segment_flags,
    output ready
  );
endinterface

// ----- src/tpor_reply_if.sv -----
// ----------------------------------------------------------------------------
// TCP reply channel
// Valid/ready channel carrying the reply decision and connection status.
// ----------------------------------------------------------------------------
interface tpor_reply_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [7:0]  reply_flags;
  logic [31:0] reply_seq;
  logic [31:0] reply_ack;
  logic [15:0] reply_port;
  logic [15:0] delivered_length;
  logic [1:0]  connection_state;
  logic [2:0]  event_code;

  modport source (
    output valid, reply_kind, reply_flags, reply_seq, reply_ack, reply_port,
           delivered_length, connection_state, event_code,
    input  ready
  );

  modport sink (
    input  valid, reply_kind, reply_flags, reply_seq, reply_ack, reply_port,
           delivered_length, connection_state, event_code,
    output ready
  );
endinterface

// ----- src/tpor_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// TCP responder configuration registers
// APB register file holding the local port, initial sequence and payload limit.
// ----------------------------------------------------------------------------
module tpor_cfg_regs
  import tpor_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_port       <= LOCAL_PORT_RESET;
      cfg.initial_sequence <= INITIAL_SEQUENCE_RESET;
      cfg.max_payload      <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LOCAL_PORT:       cfg.local_port       <= pwdata[15:0];
        REG_INITIAL_SEQUENCE: cfg.initial_sequence <= pwdata;
        REG_MAX_PAYLOAD:      cfg.max_payload      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LOCAL_PORT:       prdata = {16'd0, cfg.local_port};
      REG_INITIAL_SEQUENCE: prdata = cfg.initial_sequence;
      REG_MAX_PAYLOAD:      prdata = {16'd0, cfg.max_payload};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/tpor_core.sv -----
// ----------------------------------------------------------------------------
// TCP responder connection core
// Connection state registers and the per-segment decision logic.
// ----------------------------------------------------------------------------
module tpor_core
  import tpor_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  seg_t   seg,
  input  cfg_t   cfg,
  output reply_t res
);

  logic [1:0]  conn_state;
  logic [31:0] local_seq;
  logic [31:0] ack_to_send;
  logic [15:0] peer_port;

  logic [1:0]  conn_state_next;
  logic [31:0] local_seq_next;
  logic [31:0] ack_to_send_next;
  logic [15:0] peer_port_next;

  logic [5:0]  hdr_len;
  logic [15:0] pay_len;
  logic        pay_ok;

  assign hdr_len = {seg.data_offset, 2'b00};
  assign pay_len = (seg.ip_payload_length >= {10'd0, hdr_len}) ?
                   seg.ip_payload_length - {10'd0, hdr_len} : 16'd0;
  assign pay_ok  = (pay_len != 16'd0) && (pay_len < cfg.max_payload);

  always_comb begin
    conn_state_next      = conn_state;
    local_seq_next       = local_seq;
    ack_to_send_next     = ack_to_send;
    peer_port_next       = peer_port;
    res.reply_kind       = KIND_NONE;
    res.reply_flags      = 8'd0;
    res.delivered_length = 16'd0;
    res.event_code       = EV_OTHER;
    if (seg.dest_port != cfg.local_port) begin
      res.event_code = EV_WRONG_PORT;
    end else if (seg.segment_flags == FLAG_SYN) begin
      if (conn_state == ST_CLOSED) begin
        peer_port_next   = seg.source_port;
        local_seq_next   = cfg.initial_sequence;
        ack_to_send_next = seg.remote_seq + 32'd1;
        conn_state_next  = ST_SYNACK;
        res.reply_kind   = KIND_SYNACK;
        res.reply_flags  = FLAG_SYN | FLAG_ACK;
        res.event_code   = EV_SYN_ACCEPTED;
      end else begin
        res.event_code = EV_SYN_IGNORED;
      end
    end else if (seg.segment_flags == FLAG_ACK && conn_state == ST_SYNACK) begin
      if (seg.remote_ack == local_seq + 32'd1) begin
        conn_state_next = ST_ESTAB;
        res.event_code  = EV_ESTABLISHED;
      end else begin
        res.event_code = EV_ACK_MISMATCH;
      end
    end else if (conn_state != ST_ESTAB) begin
      res.event_code = EV_NOT_CONNECTED;
    end else if (pay_ok) begin
      ack_to_send_next     = seg.remote_seq + {16'd0, pay_len};
      local_seq_next       = seg.remote_ack;
      res.reply_kind       = KIND_ACK;
      res.reply_flags      = FLAG_ACK;
      res.delivered_length = pay_len;
      res.event_code       = EV_DATA;
    end else begin
      if ((seg.segment_flags & FLAG_ACK) != 8'd0) begin
        local_seq_next = seg.remote_ack;
      end
      res.event_code = EV_OTHER;
    end
    res.reply_seq        = local_seq_next;
    res.reply_ack        = ack_to_send_next;
    res.reply_port       = peer_port_next;
    res.connection_state = conn_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state  <= ST_CLOSED;
      local_seq   <= 32'd0;
      ack_to_send <= 32'd0;
      peer_port   <= 16'd0;
    end else if (fire) begin
      conn_state  <= conn_state_next;
      local_seq   <= local_seq_next;
      ack_to_send <= ack_to_send_next;
      peer_port   <= peer_port_next;
    end
  end

endmodule

// ----- src/tcp_passive_open_responder.sv -----
// ----------------------------------------------------------------------------
// TCP passive-open responder
// Server-side connection tracking for received TCP segment headers.
// ----------------------------------------------------------------------------
// The responder takes one segment header word per clock and returns exactly
// one reply word for each. A segment sits in an input register, the
// connection state is updated from it as the reply is loaded into an output
// register, so the sustained rate is one segment per clock while the reply
// side is not stalled.
module tcp_passive_open_responder
  import tpor_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tpor_seg_if.sink          segment,
  tpor_reply_if.source      reply,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "tcp_passive_open_responder_macros.svh"

  cfg_t   cfg;
  seg_t   seg_q;
  logic   seg_full;
  reply_t res;
  reply_t reply_q;
  logic   reply_full;
  logic   advance;
  logic   fire;

  tpor_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance       = !reply_full || reply.ready;
  assign fire          = seg_full && advance;
  assign segment.ready = !seg_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_full <= 1'b0;
    end else if (segment.valid && segment.ready) begin
      seg_full <= 1'b1;
    end else if (fire) begin
      seg_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (segment.valid && segment.ready) begin
      seg_q.ip_payload_length <= segment.ip_payload_length;
      seg_q.data_offset       <= segment.data_offset;
      seg_q.source_port       <= segment.source_port;
      seg_q.dest_port         <= segment.dest_port;
      seg_q.remote_seq        <= segment.remote_seq;
      seg_q.remote_ack        <= segment.remote_ack;
      seg_q.segment_flags     <= segment.segment_flags;
    end
  end

  tpor_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .seg  (seg_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_full <= 1'b0;
    end else if (advance) begin
      reply_full <= seg_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      reply_q <= res;
    end
  end

  assign reply.valid            = reply_full;
  assign reply.reply_kind       = reply_q.reply_kind;
  assign reply.reply_flags      = reply_q.reply_flags;
  assign reply.reply_seq        = reply_q.reply_seq;
  assign reply.reply_ack        = reply_q.reply_ack;
  assign reply.reply_port       = reply_q.reply_port;
  assign reply.delivered_length = reply_q.delivered_length;
  assign reply.connection_state = reply_q.connection_state;
  assign reply.event_code       = reply_q.event_code;

  `TPOR_ASSERT_NEXT(a_stall_holds_segment, clk, rst, seg_full && !advance, seg_full, "Held segment was lost during a stall")
  `TPOR_ASSERT_IMPL(a_synack_state, clk, rst, reply_full && reply_q.reply_kind == KIND_SYNACK, reply_q.connection_state == ST_SYNACK && reply_q.event_code == EV_SYN_ACCEPTED, "SYN-ACK reply without the SYN-ACK state")
  `TPOR_ASSERT_IMPL(a_data_event, clk, rst, reply_full && reply_q.delivered_length != 16'd0, reply_q.event_code == EV_DATA && reply_q.reply_kind == KIND_ACK, "Delivered data without a data event")
  `TPOR_ASSERT_IMPL(a_no_reply_flags, clk, rst, reply_full && reply_q.reply_kind == KIND_NONE, reply_q.reply_flags == 8'd0, "Reply flags set with no reply")

endmodule

// ----- dv/tb_tcp_passive_open_responder.sv -----
// ----------------------------------------------------------------------------
// TCP passive-open responder testbench
// Walks the connection through closed, SYN-ACK and established with directed
// segments, then sends random segment words under several register settings.
// Every reply word is checked field by field against a scoreboard that tracks
// the connection state, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_tcp_passive_open_responder;
  import tpor_pkg::*;

  localparam int PHASE_ITEMS = 200;
  localparam int PHASE_COUNT = 6;
  localparam int LONG_HOLD   = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;

  class connection_scoreboard;
    logic [15:0] local_port;
    logic [31:0] initial_sequence;
    logic [15:0] max_payload;
    logic [1:0]  conn_state;
    logic [31:0] local_seq;
    logic [31:0] ack_to_send;
    logic [15:0] peer_port;
    reply_t      expected_replies[$];
    int          mismatches;
    int          reply_count;

    function new();
      local_port       = LOCAL_PORT_RESET;
      initial_sequence = INITIAL_SEQUENCE_RESET;
      max_payload      = MAX_PAYLOAD_RESET;
      conn_state       = ST_CLOSED;
      local_seq        = '0;
      ack_to_send      = '0;
      peer_port        = '0;
      mismatches       = 0;
      reply_count      = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_LOCAL_PORT:       local_port = value[15:0];
        REG_INITIAL_SEQUENCE: initial_sequence = value;
        REG_MAX_PAYLOAD:      max_payload = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Computes the reply that an accepted segment word causes.
    function void note_segment(seg_t s);
      reply_t      want;
      logic [15:0] hdr;
      logic [15:0] pay;
      hdr = {10'b0, s.data_offset, 2'b00};
      pay = (s.ip_payload_length >= hdr) ? s.ip_payload_length - hdr : 16'd0;
      want.reply_kind       = KIND_NONE;
      want.reply_flags      = '0;
      want.delivered_length = '0;
      if (s.dest_port != local_port) begin
        want.event_code = EV_WRONG_PORT;
      end else if (s.segment_flags == FLAG_SYN) begin
        if (conn_state == ST_CLOSED) begin
          peer_port   = s.source_port;
          local_seq   = initial_sequence;
          ack_to_send = s.remote_seq + 32'd1;
          conn_state  = ST_SYNACK;
          want.reply_kind  = KIND_SYNACK;
          want.reply_flags = FLAG_SYN | FLAG_ACK;
          want.event_code  = EV_SYN_ACCEPTED;
        end else begin
          want.event_code = EV_SYN_IGNORED;
        end
      end else if (s.segment_flags == FLAG_ACK && conn_state == ST_SYNACK) begin
        if (s.remote_ack == local_seq + 32'd1) begin
          conn_state      = ST_ESTAB;
          want.event_code = EV_ESTABLISHED;
        end else begin
          want.event_code = EV_ACK_MISMATCH;
        end
      end else if (conn_state != ST_ESTAB) begin
        want.event_code = EV_NOT_CONNECTED;
      end else if (pay != 16'd0 && pay < max_payload) begin
        ack_to_send = s.remote_seq + {16'b0, pay};
        local_seq   = s.remote_ack;
        want.reply_kind       = KIND_ACK;
        want.reply_flags      = FLAG_ACK;
        want.delivered_length = pay;
        want.event_code       = EV_DATA;
      end else begin
        if ((s.segment_flags & FLAG_ACK) != 8'h00) local_seq = s.remote_ack;
        want.event_code = EV_OTHER;
      end
      want.reply_seq        = local_seq;
      want.reply_ack        = ack_to_send;
      want.reply_port       = peer_port;
      want.connection_state = conn_state;
      expected_replies.push_back(want);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("reply %0d %s got 0x%0h, expected 0x%0h",
                                  reply_count, name, got, want));
    endtask

    task check_reply(reply_t got);
      reply_t want;
      reply_count++;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d arrived with nothing expected", reply_count));
      end else begin
        want = expected_replies.pop_front();
        compare_field("reply_kind", 32'(got.reply_kind), 32'(want.reply_kind));
        compare_field("reply_flags", 32'(got.reply_flags), 32'(want.reply_flags));
        compare_field("reply_seq", got.reply_seq, want.reply_seq);
        compare_field("reply_ack", got.reply_ack, want.reply_ack);
        compare_field("reply_port", 32'(got.reply_port), 32'(want.reply_port));
        compare_field("delivered_length", 32'(got.delivered_length),
                      32'(want.delivered_length));
        compare_field("connection_state", 32'(got.connection_state),
                      32'(want.connection_state));
        compare_field("event_code", 32'(got.event_code), 32'(want.event_code));
      end
    endtask

    task flush_leftovers();
      while (expected_replies.size() != 0) begin
        void'(expected_replies.pop_front());
        report_mismatch("expected reply never arrived");
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  wire  [31:0]       prdata;
  wire               pready;

  tpor_seg_if   seg_ch();
  tpor_reply_if reply_ch();

  connection_scoreboard conn_sb = new();

  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  bit          tx_burst     = 1'b0;
  bit          tx_quiet     = 1'b0;
  logic [15:0] cur_port     = LOCAL_PORT_RESET;
  int          cur_maxpay   = int'(MAX_PAYLOAD_RESET);

  tcp_passive_open_responder DUT (
    .clk     (clk),
    .rst     (rst),
    .segment (seg_ch),
    .reply   (reply_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (seg_ch.valid && seg_ch.ready)
        conn_sb.note_segment('{seg_ch.ip_payload_length, seg_ch.data_offset,
                               seg_ch.source_port, seg_ch.dest_port, seg_ch.remote_seq,
                               seg_ch.remote_ack, seg_ch.segment_flags});
      if (reply_ch.valid && reply_ch.ready)
        conn_sb.check_reply('{reply_ch.reply_kind, reply_ch.reply_flags,
                              reply_ch.reply_seq, reply_ch.reply_ack, reply_ch.reply_port,
                              reply_ch.delivered_length, reply_ch.connection_state,
                              reply_ch.event_code});
    end
  end

  // The reply side stalls at random and serves long hold-off requests.
  initial begin : reply_sink
    int stall;
    int r;
    bit quiet;
    stall = 0;
    quiet = 1'b0;
    reply_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        reply_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        reply_ch.ready <= 1'b0;
        stall--;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        stall = LONG_HOLD - 1;
        reply_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 299) == 0) quiet = !quiet;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) begin
          reply_ch.ready <= 1'b1;
        end else if (r < 94) begin
          reply_ch.ready <= 1'b0;
          stall = $urandom_range(0, 2);
        end else begin
          reply_ch.ready <= 1'b0;
          stall = $urandom_range(6, 30);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (seg_ch.valid && seg_ch.ready) || (reply_ch.valid && reply_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 199) == 0) tx_quiet = !tx_quiet;
    if (tx_burst || tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Entered right after a rising edge; returns at the edge that accepts the word.
  task automatic send_segment(input seg_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_ch.valid             <= 1'b1;
    seg_ch.ip_payload_length <= s.ip_payload_length;
    seg_ch.data_offset       <= s.data_offset;
    seg_ch.source_port       <= s.source_port;
    seg_ch.dest_port         <= s.dest_port;
    seg_ch.remote_seq        <= s.remote_seq;
    seg_ch.remote_ack        <= s.remote_ack;
    seg_ch.segment_flags     <= s.segment_flags;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
  endtask

  // The first edge lets the monitor note the last accepted word before the
  // count of pending replies is read.
  task automatic drain_replies();
    seg_ch.valid <= 1'b0;
    @(posedge clk);
    while (conn_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    conn_sb.write_register(idx, value);
  endtask

  task automatic set_config(input logic [15:0] port, input logic [31:0] isn,
                            input logic [15:0] maxpay);
    apb_write(REG_LOCAL_PORT, {16'b0, port});
    apb_write(REG_INITIAL_SEQUENCE, isn);
    apb_write(REG_MAX_PAYLOAD, {16'b0, maxpay});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_port   = port;
    cur_maxpay = int'(maxpay);
  endtask

  function automatic seg_t segment_of(logic [15:0] plen, logic [3:0] offset,
                                      logic [15:0] sport, logic [15:0] dport,
                                      logic [31:0] rseq, logic [31:0] rack,
                                      logic [7:0] flags);
    return '{plen, offset, sport, dport, rseq, rack, flags};
  endfunction

  // Mostly well-formed data and ACK segments for the open connection, plus
  // SYNs, foreign ports and fully random words.
  function automatic seg_t random_segment();
    seg_t s;
    int   pick;
    int   hdr;
    int   lim;
    int   pay;
    s.ip_payload_length = 16'($urandom);
    s.data_offset       = 4'($urandom);
    s.source_port       = 16'($urandom);
    s.dest_port         = cur_port;
    s.remote_seq        = $urandom;
    s.remote_ack        = $urandom;
    s.segment_flags     = 8'($urandom);
    hdr  = 4 * int'(s.data_offset);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      case ($urandom_range(0, 3))
        0: s.segment_flags = FLAG_ACK | FLAG_PSH;
        1: s.segment_flags = FLAG_ACK;
        2: s.segment_flags = FLAG_PSH;
        default: s.segment_flags = 8'h00;
      endcase
      lim = cur_maxpay - 1;
      if (lim > 65535 - hdr) lim = 65535 - hdr;
      if (lim >= 1) begin
        if ($urandom_range(0, 3) == 0 || lim <= 64)
          pay = $urandom_range(1, lim);
        else
          pay = $urandom_range(1, 64);
        s.ip_payload_length = 16'(hdr + pay);
      end
    end else if (pick < 65) begin
      s.segment_flags = FLAG_ACK;
      case ($urandom_range(0, 2))
        0: s.ip_payload_length = 16'(hdr);
        1: s.ip_payload_length = 16'($urandom_range(0, hdr));
        default: if (hdr + cur_maxpay <= 65535) s.ip_payload_length = 16'(hdr + cur_maxpay);
      endcase
    end else if (pick < 73) begin
      s.segment_flags = FLAG_SYN;
    end else if (pick < 83) begin
      s.dest_port = cur_port ^ 16'($urandom_range(1, 65535));
    end else if ($urandom_range(0, 1) == 0) begin
      s.dest_port = 16'($urandom);
    end
    return s;
  endfunction

  initial begin : stimulus
    logic [15:0] p;
    logic [31:0] isn;
    rst                      <= 1'b1;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    seg_ch.valid             <= 1'b0;
    seg_ch.ip_payload_length <= '0;
    seg_ch.data_offset       <= '0;
    seg_ch.source_port       <= '0;
    seg_ch.dest_port         <= '0;
    seg_ch.remote_seq        <= '0;
    seg_ch.remote_ack        <= '0;
    seg_ch.segment_flags     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk through the connection states with the reset settings.
    p   = LOCAL_PORT_RESET;
    isn = INITIAL_SEQUENCE_RESET;
    send_segment(segment_of(16'd20, 4'd5, 16'd1234, p + 16'd1, '0, '0, FLAG_SYN));
    send_segment(segment_of(16'd0, 4'd0, 16'd0, p, '0, '0, 8'h00));
    send_segment(segment_of('1, '1, '1, p, '1, '1, 8'hFF));
    send_segment(segment_of(16'd20, 4'd5, 16'd1234, p, 32'd100, '0, FLAG_ACK));
    send_segment(segment_of(16'd20, 4'd5, 16'd1234, p, 32'd100, '0, FLAG_SYN | FLAG_ACK));
    send_segment(segment_of(16'd20, 4'd5, '1, p, '1, '0, FLAG_SYN));
    send_segment(segment_of(16'd20, 4'd5, 16'd5555, p, 32'd7, '0, FLAG_SYN));
    send_segment(segment_of(16'd20, 4'd5, '1, p, '0, isn + 32'd2, FLAG_ACK));
    send_segment(segment_of(16'd20, 4'd5, '1, p, '0, isn + 32'd1, FLAG_ACK | FLAG_PSH));
    send_segment(segment_of(16'd20, 4'd5, '1, p ^ 16'd1, '0, isn + 32'd1, FLAG_ACK));
    send_segment(segment_of(16'd20, 4'd5, '1, p, '0, isn + 32'd1, FLAG_ACK));
    send_segment(segment_of(16'd20, 4'd5, 16'd42, p, 32'd9, '0, FLAG_SYN));
    send_segment(segment_of(16'd120, 4'd5, '1, p, 32'h1000, 32'h2000, FLAG_ACK | FLAG_PSH));
    send_segment(segment_of(16'd10, 4'd15, '1, p, 32'h3000, 32'h4000, FLAG_ACK));
    send_segment(segment_of(16'd60, 4'd15, '1, p, 32'h5000, 32'h6000, FLAG_PSH));
    send_segment(segment_of(16'd61, 4'd15, '1, p, 32'h7000, 32'h8000, 8'h00));
    send_segment(segment_of(16'd1019, 4'd5, '1, p, 32'h9000, 32'hA000, FLAG_ACK | FLAG_PSH));
    send_segment(segment_of(16'd1020, 4'd5, '1, p, 32'hB000, 32'hC000, FLAG_ACK | FLAG_PSH));
    send_segment(segment_of(16'd1020, 4'd5, '1, p, 32'hD000, 32'hE000, FLAG_PSH));
    send_segment(segment_of('1, 4'd0, '1, p, 32'h1, 32'h2, FLAG_ACK));
    send_segment(segment_of(16'd36, 4'd5, '1, p, 32'hFFFF_FFF8, '1, FLAG_ACK | FLAG_PSH));
    send_segment(segment_of(16'd0, 4'd0, 16'd0, p, '0, '0, 8'h00));
    send_segment(segment_of('1, '1, '1, p, '1, '1, 8'hFF));

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_replies();
      case (phase)
        0: set_config(16'd0, 32'd0, 16'd1);
        1: set_config(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        2: set_config(16'($urandom), $urandom, 16'd0);
        3: set_config(16'($urandom), $urandom, 16'd1000);
        4: set_config(16'($urandom), $urandom, 16'($urandom_range(2, 100)));
        default: set_config(16'($urandom), $urandom, 16'($urandom_range(1, 65535)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // The reply side holds off while segments keep coming back to back.
        if (phase == 1 && i == 20) begin
          holds_asked++;
          tx_burst = 1'b1;
        end
        if (phase == 1 && i == 140) tx_burst = 1'b0;
        send_segment(random_segment());
      end
    end

    drain_replies();
    repeat (10) @(posedge clk);
    conn_sb.flush_leftovers();
    if (conn_sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
